/* design/cdf_gs_pkg.sv */
// ----------------------------------------------------------------------------
// CDF table Gaussian sampler package
// Stream field layout and widths shared by the sampler and its port
// checker, and the sampler's sequencer state type.
// ----------------------------------------------------------------------------
package cdf_gs_pkg;

    // Input item fields (tdata, lowest bit first: set, index, entry, random)
    localparam int SET_W      = 3;
    localparam int INDEX_W    = 8;
    localparam int WORD_W     = 64;
    localparam int SET_LSB    = 0;
    localparam int INDEX_LSB  = SET_LSB + SET_W;
    localparam int ENTRY_LSB  = INDEX_LSB + INDEX_W;
    localparam int RANDOM_LSB = ENTRY_LSB + WORD_W;
    localparam int IN_BITS    = RANDOM_LSB + WORD_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // Result item field
    localparam int SAMPLE_W    = 9;
    localparam int OUT_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;

    // tuser codes
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_OUT
    } state_t;

endpackage

/* design/cdf_table_gaussian_sampler.sv */
// A sample item searches after acceptance, one table read and compare per
// halving step, then presents its signed result in ST_OUT until m_tready.
// The input stays closed from acceptance of a sample until its result is
// taken, so a new item is not accepted while a sample is in flight.
// Table writes leave the input open; a sample on an absent set yields zero.
// Reset (aresetn low, synchronous) idles the sequencer; tables keep contents.
// ----------------------------------------------------------------------------
// CDF table Gaussian sampler
// Stores cumulative probability tables and draws signed samples by a binary
// search over one table, one probe per cycle through a shared compare unit.
// ----------------------------------------------------------------------------
module cdf_table_gaussian_sampler
    import cdf_gs_pkg::*;
#(
    parameter int TABLE_SIZE  = 256,
    parameter int SEARCH_STEP = 128,
    parameter int NUM_SETS    = 5
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // set, index, entry, random, zero pad
    input  logic                   s_tuser,   // func
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // sample, zero pad
);

    localparam int DEPTH = NUM_SETS * TABLE_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(TABLE_SIZE);
    localparam int SW    = $clog2(SEARCH_STEP + 1);
    localparam int QW    = ((PW > SW) ? PW : SW) + 1;
    localparam int IXW   = ($clog2(TABLE_SIZE + 1) > INDEX_W) ?
                           $clog2(TABLE_SIZE + 1) : INDEX_W;
    localparam int MW    = (PW > SAMPLE_W) ? PW : SAMPLE_W;
    localparam int SETCW = SET_W + 1;

    localparam logic [QW-1:0] TABLE_END   = QW'(TABLE_SIZE);
    localparam logic [QW-1:0] FIRST_PROBE = QW'(SEARCH_STEP);

    // Input fields
    logic [SET_W-1:0]   in_set;
    logic [INDEX_W-1:0] in_index;
    logic [WORD_W-1:0]  in_entry;
    logic [WORD_W-1:0]  in_random;
    logic               in_set_ok;
    logic               in_idx_ok;
    logic [AW-1:0]      in_base;
    logic               in_accept;

    assign in_set    = s_tdata[SET_LSB +: SET_W];
    assign in_index  = s_tdata[INDEX_LSB +: INDEX_W];
    assign in_entry  = s_tdata[ENTRY_LSB +: WORD_W];
    assign in_random = s_tdata[RANDOM_LSB +: WORD_W];
    assign in_set_ok = SETCW'(in_set) < SETCW'(NUM_SETS);
    assign in_idx_ok = IXW'(in_index) < IXW'(TABLE_SIZE);
    assign in_base   = AW'(AW'(in_set) * AW'(TABLE_SIZE));
    assign in_accept = s_tvalid && s_tready;

    // Sequencer and datapath registers
    state_t              state_reg, state_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [SW-1:0]       step_reg, step_next;
    logic [AW-1:0]       base_reg, base_next;
    logic [WORD_W-1:0]   key_reg, key_next;
    logic [SAMPLE_W-1:0] sample_reg, sample_next;

    // Table memory
    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;

    // Search step
    logic [QW-1:0] probe;
    logic          hit;
    logic [PW-1:0] pos_step;
    logic [SW-1:0] step_half;
    logic [QW-1:0] next_probe;
    logic [MW-1:0] mag_ext;
    logic [MW-1:0] signed_val;

    assign wr_en   = in_accept && (s_tuser == FUNC_WRITE) && in_set_ok && in_idx_ok;
    assign wr_addr = in_base + AW'(in_index);

    assign probe      = QW'(pos_reg) + QW'(step_reg);
    assign hit        = (probe < TABLE_END) && (key_reg >= rdata_reg);
    assign pos_step   = hit ? probe[PW-1:0] : pos_reg;
    assign step_half  = step_reg >> 1;
    assign next_probe = QW'(pos_step) + QW'(step_half);
    assign mag_ext    = MW'(pos_step);
    assign signed_val = key_reg[0] ? mag_ext : (MW'(0) - mag_ext);

    always_comb begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        step_next   = step_reg;
        base_next   = base_reg;
        key_next    = key_reg;
        sample_next = sample_reg;
        rd_en       = 1'b0;
        rd_addr     = base_reg + AW'(next_probe[PW-1:0]);
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                rd_addr  = in_base + AW'(FIRST_PROBE[PW-1:0]);
                if (s_tvalid && (s_tuser == FUNC_SAMPLE)) begin
                    if (in_set_ok) begin
                        // first probe goes out now, its word returns next cycle
                        rd_en      = (FIRST_PROBE < TABLE_END);
                        pos_next   = '0;
                        step_next  = SW'(SEARCH_STEP);
                        base_next  = in_base;
                        key_next   = in_random;
                        state_next = ST_SEARCH;
                    end else begin
                        sample_next = '0;
                        state_next  = ST_OUT;
                    end
                end
            end
            ST_SEARCH: begin
                pos_next  = pos_step;
                step_next = step_half;
                if (step_half == '0) begin
                    sample_next = signed_val[SAMPLE_W-1:0];
                    state_next  = ST_OUT;
                end else begin
                    rd_en = (next_probe < TABLE_END);
                end
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        step_reg   <= step_next;
        base_reg   <= base_next;
        key_reg    <= key_next;
        sample_reg <= sample_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= in_entry;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign m_tdata = OUT_TDATA_W'(sample_reg);

endmodule

/* design/cdf_gs_check.sv */
// ----------------------------------------------------------------------------
// CDF table Gaussian sampler port checker
// Watches the sampler's stream ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module cdf_gs_check
    import cdf_gs_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   s_tuser,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // one item at a time: no intake while a result waits
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // a sample item closes the input straight after it is taken
    a_sample_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == FUNC_SAMPLE) |=> !s_tready)
        else $error("input reopened right after a sample item");

    // a table write causes no result and leaves the input open
    a_write_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == FUNC_WRITE) |=> s_tready && !m_tvalid)
        else $error("table write disturbed the sequencer");

    // pad bits above the sample stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_TDATA_W-1:SAMPLE_W] == '0))
        else $error("result pad bits not zero");

endmodule

bind cdf_table_gaussian_sampler cdf_gs_check u_cdf_gs_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
